>>> sv/sound_chip_voice_register_writer_defines.svh
// Assertion macros for the sound chip voice register writer.
// No dependencies; included by the modules that carry assertions.
`ifndef SOUND_CHIP_VOICE_REGISTER_WRITER_DEFINES_SVH
`define SOUND_CHIP_VOICE_REGISTER_WRITER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SCV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SCV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/scvrw_pkg.sv
// Shared types, constants and tables of the sound chip voice register writer.
// No dependencies.
package scvrw_pkg;

  localparam int NumChipsDef  = 4;
  localparam int NumVoicesDef = 16;

  localparam logic [13:0] NoteMax = 14'd16256;
  localparam logic [3:0] MixReg     = 4'd8;
  localparam logic [3:0] TimerReg   = 4'd9;
  localparam logic [3:0] LowFiltReg = 4'd4;
  localparam logic [3:0] HighFiltReg = 4'd6;
  localparam logic [3:0] SerialReg  = 4'd15;

  typedef enum logic [2:0] {
    CMD_NOTE = 3'd0, CMD_VOL = 3'd1, CMD_MODE = 3'd2, CMD_DIST = 3'd3, CMD_FILT = 3'd4
  } cmd_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  chip;
    logic [1:0]  ch;
    logic [4:0]  mode;
    logic [13:0] note;
    logic [15:0] opnd;
  } job_t;

  // One register write.
  typedef struct packed {
    logic [1:0] chip;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } wr_t;

  function automatic logic [15:0] div_base(input logic [6:0] i);
    logic [15:0] t [0:127];
    t = '{16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,
          16'hFFFF,16'hFFFF,16'hFFFF,16'hFD12,16'hEEDD,16'hE175,16'hD4CD,16'hC8DB,
          16'hBD95,16'hB2F0,16'hA8E5,16'h9F6A,16'h9677,16'h8E05,16'h860C,16'h7E85,
          16'h776B,16'h70B7,16'h6A63,16'h646A,16'h5EC7,16'h5975,16'h546F,16'h4FB1,
          16'h4B38,16'h46FF,16'h4302,16'h3F3F,16'h3BB2,16'h3858,16'h352E,16'h3231,
          16'h2F60,16'h2CB7,16'h2A34,16'h27D5,16'h2598,16'h237C,16'h217E,16'h1F9C,
          16'h1DD6,16'h1C28,16'h1A93,16'h1915,16'h17AC,16'h1658,16'h1516,16'h13E7,
          16'h12C9,16'h11BA,16'h10BB,16'h0FCB,16'h0EE7,16'h0E11,16'h0D46,16'h0C87,
          16'h0BD3,16'h0B28,16'h0A88,16'h09F0,16'h0961,16'h08DA,16'h085A,16'h07E2,
          16'h0770,16'h0705,16'h06A0,16'h0640,16'h05E6,16'h0591,16'h0540,16'h04F5,
          16'h04AD,16'h0469,16'h042A,16'h03ED,16'h03B5,16'h037F,16'h034C,16'h031D,
          16'h02EF,16'h02C5,16'h029D,16'h0277,16'h0253,16'h0231,16'h0211,16'h01F3,
          16'h01D7,16'h01BC,16'h01A3,16'h018B,16'h0174,16'h015F,16'h014B,16'h0138,
          16'h0126,16'h0115,16'h0105,16'h00F6,16'h00E8,16'h00DA,16'h00CE,16'h00C2,
          16'h00B7,16'h00AC,16'h00A2,16'h0098,16'h008F,16'h0087,16'h007F,16'h0078,
          16'h0070,16'h006A,16'h0063,16'h005D,16'h0058,16'h0052,16'h004D,16'h0049};
    return t[i];
  endfunction

  function automatic logic [15:0] div_114(input logic [6:0] i);
    logic [15:0] t [0:127];
    t = '{16'h0430,16'h03F4,16'h03BB,16'h0385,16'h0353,16'h0323,16'h02F6,16'h02CB,
          16'h02A3,16'h027D,16'h0259,16'h0237,16'h0217,16'h01F9,16'h01DD,16'h01C2,
          16'h01A9,16'h0191,16'h017A,16'h0165,16'h0151,16'h013E,16'h012C,16'h011B,
          16'h010B,16'h00FC,16'h00EE,16'h00E1,16'h00D4,16'h00C8,16'h00BD,16'h00B2,
          16'h00A8,16'h009E,16'h0096,16'h008D,16'h0085,16'h007E,16'h0076,16'h0070,
          16'h0069,16'h0063,16'h005E,16'h0059,16'h0053,16'h004F,16'h004A,16'h0046,
          16'h0042,16'h003E,16'h003B,16'h0037,16'h0034,16'h0031,16'h002E,16'h002C,
          16'h0029,16'h0027,16'h0025,16'h0023,16'h0021,16'h001F,16'h001D,16'h001B,
          16'h001A,16'h0018,16'h0017,16'h0015,16'h0014,16'h0013,16'h0012,16'h0011,
          16'h0010,16'h000F,16'h000E,16'h000D,16'h000C,16'h000C,16'h000B,16'h000A,
          16'h000A,16'h0009,16'h0008,16'h0008,16'h0007,16'h0007,16'h0006,16'h0006,
          16'h0006,16'h0005,16'h0005,16'h0005,16'h0004,16'h0004,16'h0004,16'h0003,
          16'h0003,16'h0003,16'h0003,16'h0003,16'h0002,16'h0002,16'h0002,16'h0002,
          16'h0002,16'h0001,16'h0001,16'h0001,16'h0001,16'h0001,16'h0001,16'h0001,
          16'h0001,16'h0001,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
          16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000};
    return t[i];
  endfunction

  function automatic logic [15:0] div_28(input logic [6:0] i);
    logic [15:0] t [0:127];
    t = '{16'h110F,16'h101A,16'h0F33,16'h0E58,16'h0D8A,16'h0CC8,16'h0C10,16'h0B62,
          16'h0ABF,16'h0A24,16'h0993,16'h0909,16'h0887,16'h080D,16'h0799,16'h072C,
          16'h06C5,16'h0663,16'h0607,16'h05B1,16'h055F,16'h0512,16'h04C9,16'h0484,
          16'h0443,16'h0406,16'h03CC,16'h0395,16'h0362,16'h0331,16'h0303,16'h02D8,
          16'h02AF,16'h0288,16'h0264,16'h0242,16'h0221,16'h0202,16'h01E5,16'h01CA,
          16'h01B0,16'h0198,16'h0181,16'h016B,16'h0157,16'h0144,16'h0131,16'h0120,
          16'h0110,16'h0101,16'h00F2,16'h00E5,16'h00D8,16'h00CC,16'h00C0,16'h00B5,
          16'h00AB,16'h00A1,16'h0098,16'h0090,16'h0088,16'h0080,16'h0079,16'h0072,
          16'h006B,16'h0065,16'h0060,16'h005A,16'h0055,16'h0050,16'h004C,16'h0047,
          16'h0043,16'h003F,16'h003C,16'h0038,16'h0035,16'h0032,16'h002F,16'h002D,
          16'h002A,16'h0028,16'h0025,16'h0023,16'h0021,16'h001F,16'h001D,16'h001C,
          16'h001A,16'h0019,16'h0017,16'h0016,16'h0014,16'h0013,16'h0012,16'h0011,
          16'h0010,16'h000F,16'h000E,16'h000D,16'h000D,16'h000C,16'h000B,16'h000A,
          16'h000A,16'h0009,16'h0009,16'h0008,16'h0008,16'h0007,16'h0007,16'h0006,
          16'h0006,16'h0005,16'h0005,16'h0005,16'h0004,16'h0004,16'h0004,16'h0004,
          16'h0003,16'h0003,16'h0003,16'h0003,16'h0002,16'h0002,16'h0002,16'h0002};
    return t[i];
  endfunction

  // Divider table lookup; sel picks 0 base/28, 1 base/114, 2 base. Index 128 follows the top note.
  function automatic logic [15:0] div_lookup(input logic [1:0] sel, input logic [7:0] idx);
    logic [15:0] v;
    v = '0;
    case (sel)
      2'd0: v = idx[7] ? 16'h0002 : div_28(idx[6:0]);
      2'd1: v = idx[7] ? 16'h0000 : div_114(idx[6:0]);
      default: v = idx[7] ? 16'h0044 : div_base(idx[6:0]);
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dist_bits(input logic [3:0] d);
    logic [7:0] v;
    case (d)
      4'd0: v = 8'hA0;
      4'd3, 4'd4: v = 8'h80;
      4'd5: v = 8'h60;
      4'd6: v = 8'h40;
      4'd7: v = 8'hC0;
      4'd8: v = 8'hF0;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic signed [2:0] jitter(input logic [3:0] r);
    logic signed [2:0] v;
    case (r)
      4'd0, 4'd9: v = 3'sd2;
      4'd1, 4'd4, 4'd10, 4'd13: v = 3'sd1;
      4'd3, 4'd6, 4'd12: v = -3'sd1;
      4'd7: v = -3'sd2;
      4'd8: v = -3'sd3;
      default: v = 3'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] chan_cfg(input logic [4:0] m, input logic pair);
    logic [7:0] v;
    if (pair && m >= 5'd6) v = 8'hFF;
    else begin
      case (m)
        5'd0, 5'd6: v = 8'h00;
        5'd1, 5'd8: v = 8'h11;
        5'd2, 5'd10, 5'd11, 5'd12: v = 8'h2F;
        5'd3, 5'd13, 5'd21, 5'd22: v = 8'hF3;
        5'd4, 5'd14, 5'd23, 5'd24: v = 8'hF4;
        5'd7: v = 8'h0F;
        5'd9: v = 8'h1F;
        5'd17, 5'd18: v = 8'hF0;
        5'd19, 5'd20: v = 8'hF1;
        default: v = 8'hF5;
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] actl_clr(input logic [4:0] m, input logic [1:0] c);
    logic [31:0] r;
    case (m)
      5'd0: r = 32'h55132D0B; 5'd1: r = 32'h54122C0A; 5'd2: r = 32'h14000C00;
      5'd3: r = 32'h00470027; 5'd4: r = 32'h00460026; 5'd5: r = 32'h00060006;
      5'd6: r = 32'h79190000; 5'd7: r = 32'h59000000; 5'd8: r = 32'h78180000;
      5'd9: r = 32'h58000000; 5'd10: r = 32'h39000000; 5'd11: r = 32'h38000000;
      5'd12: r = 32'h18000000; 5'd13: r = 32'h004D0000; 5'd14: r = 32'h004C0000;
      5'd15: r = 32'h000D0000; 5'd16: r = 32'h000C0000; 5'd17: r = 32'h00750000;
      5'd18: r = 32'h00550000; 5'd19: r = 32'h00740000; 5'd20: r = 32'h00540000;
      5'd21: r = 32'h00650000; 5'd22: r = 32'h00450000; 5'd23: r = 32'h00640000;
      5'd24: r = 32'h00440000; 5'd25: r = 32'h00250000; 5'd26: r = 32'h00240000;
      5'd27: r = 32'h00040000; default: r = '0;
    endcase
    return r[8*(3-c) +: 8];
  endfunction

  function automatic logic [7:0] actl_set(input logic [4:0] m, input logic [1:0] c);
    logic [31:0] r;
    case (m)
      5'd0: r = 32'h00000000; 5'd1: r = 32'h01010101; 5'd2: r = 32'h40002000;
      5'd3: r = 32'h00100008; 5'd4: r = 32'h00110009; 5'd5: r = 32'h00500028;
      5'd6: r = 32'h04020000; 5'd7: r = 32'h24000000; 5'd8: r = 32'h05030000;
      5'd9: r = 32'h25000000; 5'd10: r = 32'h44000000; 5'd11: r = 32'h45000000;
      5'd12: r = 32'h64000000; 5'd13: r = 32'h00120000; 5'd14: r = 32'h00130000;
      5'd15: r = 32'h00520000; 5'd16: r = 32'h00530000; 5'd17: r = 32'h000A0000;
      5'd18: r = 32'h002A0000; 5'd19: r = 32'h000B0000; 5'd20: r = 32'h002B0000;
      5'd21: r = 32'h001A0000; 5'd22: r = 32'h003A0000; 5'd23: r = 32'h001B0000;
      5'd24: r = 32'h003B0000; 5'd25: r = 32'h005A0000; 5'd26: r = 32'h005B0000;
      5'd27: r = 32'h007A0000; default: r = '0;
    endcase
    return r[8*(3-c) +: 8];
  endfunction

endpackage

>>> sv/scvrw_front.sv
// Front end: accepts commands, keeps the per-voice oscillator modes, drops commands
// that are ignored and pushes classified jobs into a short queue. Uses scvrw_pkg.
module scvrw_front #(
  parameter int NUM_CHIPS  = scvrw_pkg::NumChipsDef,
  parameter int NUM_VOICES = scvrw_pkg::NumVoicesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        cmd,
  input  logic [3:0]        voice,
  input  logic signed [15:0] pitch,
  input  logic [15:0]       operand,
  output scvrw_pkg::job_t   job,
  output logic              job_valid,
  input  logic              job_take
);
  localparam int Depth = 2;

  logic [4:0] voice_mode [NUM_VOICES];
  scvrw_pkg::job_t q [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       acc, keep;
  logic [4:0] mode;
  logic [1:0] chip;
  logic [13:0] note;
  scvrw_pkg::job_t nj;

  assign full = (count == 2'(Depth));
  assign acc  = push && !full;
  assign chip = voice[3:2];
  assign mode = (32'(voice) < NUM_VOICES) ? voice_mode[voice] : 5'd0;

  always_comb begin
    if (pitch < 0) note = '0;
    else if (pitch > 16'sd16256) note = scvrw_pkg::NoteMax;
    else note = pitch[13:0];
    nj.cmd = cmd; nj.chip = chip; nj.ch = voice[1:0]; nj.mode = mode;
    nj.note = note; nj.opnd = operand;
    keep = (32'(voice) < NUM_VOICES) && (32'(chip) < NUM_CHIPS);
    case (cmd)
      scvrw_pkg::CMD_NOTE, scvrw_pkg::CMD_VOL: ;
      scvrw_pkg::CMD_MODE: keep = keep && (operand < 16'd28);
      scvrw_pkg::CMD_DIST: keep = keep && (operand < 16'd9);
      scvrw_pkg::CMD_FILT: keep = keep &&
        ((voice[1:0] == 2'd0 && mode >= 5'd6 && mode < 5'd13) ||
         (voice[1:0] == 2'd1 && (mode == 5'd6 || mode == 5'd8 || mode >= 5'd13)));
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) voice_mode[i] <= '0;
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= '0;
    end else begin
      if (acc && keep && cmd == scvrw_pkg::CMD_MODE) voice_mode[voice] <= operand[4:0];
      if (acc && keep) begin
        q[wr_ptr] <= nj;
        wr_ptr <= ~wr_ptr;
      end
      if (job_valid && job_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(acc && keep) - 2'(job_valid && job_take);
    end
  end

  assign job_valid = (count != '0);
  assign job = q[rd_ptr];

  `include "sound_chip_voice_register_writer_defines.svh"
  `SCV_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, count <= 2'(Depth), "queue count overflow")
  `SCV_ASSERT_NEXT(a_push_cnt, clk, rst, acc && keep && !(job_valid && job_take),
                   count == $past(count) + 2'd1, "queue count missed a push")
  `SCV_ASSERT_IMP(a_ptr, clk, rst, count == 2'(Depth), wr_ptr == rd_ptr, "pointer mismatch")
endmodule

>>> sv/scvrw_back.sv
// Back end: takes jobs, shadows the registers that are read back, computes dividers
// and emits register writes one per cycle while the output queue has room. Uses scvrw_pkg.
module scvrw_back #(
  parameter int NUM_CHIPS = scvrw_pkg::NumChipsDef
) (
  input  logic            clk,
  input  logic            rst,
  input  scvrw_pkg::job_t job,
  input  logic            job_valid,
  output logic            job_take,
  output logic            empty,
  input  logic            pop,
  output logic [1:0]      chip_sel,
  output logic [3:0]      reg_addr,
  output logic [7:0]      reg_data,
  output logic            last
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_MUL = 3'b010, S_EMIT = 3'b100
  } state_t;

  state_t state;
  scvrw_pkg::job_t cur;
  // Only the channel control registers and the mix register are ever read back,
  // so only those are shadowed; the other registers are write-only.
  logic [7:0]  ctl_sh [NUM_CHIPS*4];
  logic [7:0]  mix_sh [NUM_CHIPS];
  logic [15:0] v0, v1, diff;
  logic [6:0]  rem;
  logic        interp;
  logic [1:0]  sel;
  logic [22:0] prod;
  logic [15:0] value, value_next;
  scvrw_pkg::wr_t w [3];
  logic [1:0]  nw, wi;
  logic [1:0]  oq_cnt;
  scvrw_pkg::wr_t oq [2];
  logic        oq_wp, oq_rp;
  logic        emit_go;
  scvrw_pkg::wr_t ew;

  // Remainder by 15 from nibble sums (16 is 1 mod 15).
  function automatic logic [3:0] mod15(input logic [15:0] v);
    logic [5:0] s;
    logic [4:0] t;
    s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
    t = 5'(s[3:0]) + 5'(s[5:4]);
    return (t >= 5'd15) ? 4'(t - 5'd15) : t[3:0];
  endfunction

  // Divider select from the job, combinational on the held job.
  logic [7:0] cfg;
  logic [3:0] nib;
  always_comb begin
    cfg = scvrw_pkg::chan_cfg(cur.mode, cur.ch[1]);
    nib = cur.ch[0] ? cfg[3:0] : cfg[7:4];
  end

  // Writes for the held job, built from the shadow; later writes see earlier ones.
  always_comb begin
    logic [7:0] ctl, mix, d;
    logic signed [17:0] jv;
    logic [15:0] jval;
    logic [3:0] a;
    w[0] = '0; w[1] = '0; w[2] = '0; nw = '0;
    a = {1'b0, cur.ch, 1'b0};
    ctl = ctl_sh[{cur.chip, cur.ch}];
    mix = mix_sh[cur.chip];
    jv = '0; jval = '0; d = '0;
    case (cur.cmd)
      scvrw_pkg::CMD_NOTE: begin
        if (nib < 4'd3) begin
          w[0] = '{cur.chip, a, (value > 16'd255) ? 8'hFF : value[7:0], 1'b1};
          nw = 2'd1;
        end else if (nib < 4'd6 && a >= 4'd2) begin
          if (ctl[7:4] == 4'hC) begin
            jv = 18'(signed'({2'b00, value})) + 18'(scvrw_pkg::jitter(mod15(value)));
            if (jv < 0) jval = '0;
            else if (jv > 18'sd65535) jval = 16'hFFFF;
            else jval = jv[15:0];
            w[0] = '{cur.chip, a, jval[15:8], 1'b0};
            w[1] = '{cur.chip, a - 4'd2, jval[7:0], 1'b0};
            w[2] = '{cur.chip, scvrw_pkg::TimerReg, 8'h00, 1'b1};
            nw = 2'd3;
          end else begin
            w[0] = '{cur.chip, a, value[15:8], 1'b0};
            w[1] = '{cur.chip, a - 4'd2, value[7:0], 1'b1};
            nw = 2'd2;
          end
        end
      end
      scvrw_pkg::CMD_VOL: begin
        d = (cur.opnd > 16'd127) ? 8'd15 : 8'(cur.opnd[6:3]);
        w[0] = '{cur.chip, a | 4'd1, d | (ctl & 8'hF0), 1'b1};
        nw = 2'd1;
      end
      scvrw_pkg::CMD_MODE: begin
        d = (mix & ~scvrw_pkg::actl_clr(cur.opnd[4:0], cur.ch)) |
            scvrw_pkg::actl_set(cur.opnd[4:0], cur.ch);
        w[0] = '{cur.chip, scvrw_pkg::MixReg, d, 1'b1};
        nw = 2'd1;
      end
      scvrw_pkg::CMD_DIST: begin
        w[0] = '{cur.chip, a | 4'd1, (ctl & 8'h0F) | scvrw_pkg::dist_bits(cur.opnd[3:0]), 1'b0};
        d = (cur.opnd == 16'd2 || cur.opnd == 16'd4) ? (mix | 8'h80) : (mix & 8'h7F);
        w[1] = '{cur.chip, scvrw_pkg::MixReg, d, 1'b1};
        nw = 2'd2;
      end
      scvrw_pkg::CMD_FILT: begin
        if (cur.ch == 2'd0) begin
          w[0] = '{cur.chip, scvrw_pkg::LowFiltReg, cur.opnd[15:8], 1'b1};
          nw = 2'd1;
        end else begin
          w[0] = '{cur.chip, scvrw_pkg::HighFiltReg, cur.opnd[15:8], !(cur.mode >= 5'd17)};
          w[1] = '{cur.chip, scvrw_pkg::LowFiltReg, cur.opnd[7:0], 1'b1};
          nw = (cur.mode >= 5'd17) ? 2'd2 : 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Interpolation operands
  always_comb begin
    sel = (nib == 4'd0 || nib == 4'd3) ? 2'd0 : (nib == 4'd1 || nib == 4'd4) ? 2'd1 : 2'd2;
    v0 = scvrw_pkg::div_lookup(sel, {1'b0, cur.note[13:7]});
    v1 = scvrw_pkg::div_lookup(sel, {1'b0, cur.note[13:7]} + 8'd1);
    rem = cur.note[6:0];
    interp = (rem != '0) && (v0 >= v1);
    diff = v0 - v1;
  end

  assign emit_go = (state == S_EMIT) && (oq_cnt != 2'd2);
  assign ew = w[wi];
  assign job_take = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; wi <= '0;
      for (int i = 0; i < NUM_CHIPS*4; i++) ctl_sh[i] <= 8'hA0;
      for (int c = 0; c < NUM_CHIPS; c++) mix_sh[c] <= 8'h00;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          cur <= job; state <= S_MUL; wi <= '0;
        end
        S_MUL: begin
          value <= value_next;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (nw == '0) state <= S_IDLE;
          else if (emit_go) begin
            if (!ew.addr[3] && ew.addr[0]) ctl_sh[{ew.chip, ew.addr[2:1]}] <= ew.data;
            if (ew.addr == scvrw_pkg::MixReg) mix_sh[ew.chip] <= ew.data;
            if (wi == nw - 2'd1) state <= S_IDLE;
            wi <= wi + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    prod = 23'(diff) * 23'(rem);
    value_next = interp ? (v0 - 16'(prod >> 7)) : v0;
  end

  // Output queue, two entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_cnt <= '0; oq_wp <= 1'b0; oq_rp <= 1'b0;
    end else begin
      if (emit_go && nw != '0) begin
        oq[oq_wp] <= ew; oq_wp <= ~oq_wp;
      end
      if (!empty && pop) oq_rp <= ~oq_rp;
      oq_cnt <= oq_cnt + 2'(emit_go && nw != '0) - 2'(!empty && pop);
    end
  end

  assign empty = (oq_cnt == '0);
  assign chip_sel = oq[oq_rp].chip;
  assign reg_addr = oq[oq_rp].addr;
  assign reg_data = oq[oq_rp].data;
  assign last = oq[oq_rp].last;

  `include "sound_chip_voice_register_writer_defines.svh"
  `SCV_ASSERT_IMP(a_oq_range, clk, rst, 1'b1, oq_cnt <= 2'd2, "output queue overflow")
  `SCV_ASSERT_IMP(a_take_idle, clk, rst, job_take, state == S_IDLE, "job taken while busy")
  `SCV_ASSERT_NEXT(a_mul_emit, clk, rst, state == S_MUL, state == S_EMIT, "multiply step skipped")
endmodule

>>> sv/sound_chip_voice_register_writer.sv
// Top level of the sound chip voice register writer.
// Uses scvrw_pkg, scvrw_front and scvrw_back.

// Turns voice commands into zero to three chip register writes. The front end
// accepts a command every cycle while its two-entry job queue is not full; the
// back end takes a job, does the divider interpolation multiply and then emits
// one write per cycle into a two-entry output queue while that queue has room.
// Commands that are ignored (voice out of range, bad operand, filter not used in
// the voice's mode, unknown code) are dropped in the front end and cost no
// back-end time; a note on a channel with no divider in its mode still passes to
// the back end and goes through the multiply step there with no write.
module sound_chip_voice_register_writer #(
  parameter int NUM_CHIPS  = scvrw_pkg::NumChipsDef,
  parameter int NUM_VOICES = scvrw_pkg::NumVoicesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cmd,
  input  logic [3:0]         voice,
  input  logic signed [15:0] pitch,
  input  logic [15:0]        operand,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         chip_sel,
  output logic [3:0]         reg_addr,
  output logic [7:0]         reg_data,
  output logic               last
);
  scvrw_pkg::job_t job;
  logic job_valid, job_take;

  scvrw_front #(.NUM_CHIPS(NUM_CHIPS), .NUM_VOICES(NUM_VOICES)) u_front (
    .clk, .rst, .push, .full, .cmd, .voice, .pitch, .operand,
    .job, .job_valid, .job_take
  );

  scvrw_back #(.NUM_CHIPS(NUM_CHIPS)) u_back (
    .clk, .rst, .job, .job_valid, .job_take,
    .empty, .pop, .chip_sel, .reg_addr, .reg_data, .last
  );
endmodule

>>> dv/tb_sound_chip_voice_register_writer.sv
// Testbench for sound_chip_voice_register_writer: queue-style drivers, a
// scoreboard class with its own register-write predictor, random idling.
// Depends on scvrw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sound_chip_voice_register_writer;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [15:0] BASE_DIV [129] = '{
    16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,
    16'hFFFF,16'hFD12,16'hEEDD,16'hE175,16'hD4CD,16'hC8DB,16'hBD95,16'hB2F0,16'hA8E5,16'h9F6A,
    16'h9677,16'h8E05,16'h860C,16'h7E85,16'h776B,16'h70B7,16'h6A63,16'h646A,16'h5EC7,16'h5975,
    16'h546F,16'h4FB1,16'h4B38,16'h46FF,16'h4302,16'h3F3F,16'h3BB2,16'h3858,16'h352E,16'h3231,
    16'h2F60,16'h2CB7,16'h2A34,16'h27D5,16'h2598,16'h237C,16'h217E,16'h1F9C,16'h1DD6,16'h1C28,
    16'h1A93,16'h1915,16'h17AC,16'h1658,16'h1516,16'h13E7,16'h12C9,16'h11BA,16'h10BB,16'h0FCB,
    16'h0EE7,16'h0E11,16'h0D46,16'h0C87,16'h0BD3,16'h0B28,16'h0A88,16'h09F0,16'h0961,16'h08DA,
    16'h085A,16'h07E2,16'h0770,16'h0705,16'h06A0,16'h0640,16'h05E6,16'h0591,16'h0540,16'h04F5,
    16'h04AD,16'h0469,16'h042A,16'h03ED,16'h03B5,16'h037F,16'h034C,16'h031D,16'h02EF,16'h02C5,
    16'h029D,16'h0277,16'h0253,16'h0231,16'h0211,16'h01F3,16'h01D7,16'h01BC,16'h01A3,16'h018B,
    16'h0174,16'h015F,16'h014B,16'h0138,16'h0126,16'h0115,16'h0105,16'h00F6,16'h00E8,16'h00DA,
    16'h00CE,16'h00C2,16'h00B7,16'h00AC,16'h00A2,16'h0098,16'h008F,16'h0087,16'h007F,16'h0078,
    16'h0070,16'h006A,16'h0063,16'h005D,16'h0058,16'h0052,16'h004D,16'h0049,16'h0044};
  localparam logic [15:0] DIV114 [129] = '{
    16'h0430,16'h03F4,16'h03BB,16'h0385,16'h0353,16'h0323,16'h02F6,16'h02CB,16'h02A3,16'h027D,
    16'h0259,16'h0237,16'h0217,16'h01F9,16'h01DD,16'h01C2,16'h01A9,16'h0191,16'h017A,16'h0165,
    16'h0151,16'h013E,16'h012C,16'h011B,16'h010B,16'h00FC,16'h00EE,16'h00E1,16'h00D4,16'h00C8,
    16'h00BD,16'h00B2,16'h00A8,16'h009E,16'h0096,16'h008D,16'h0085,16'h007E,16'h0076,16'h0070,
    16'h0069,16'h0063,16'h005E,16'h0059,16'h0053,16'h004F,16'h004A,16'h0046,16'h0042,16'h003E,
    16'h003B,16'h0037,16'h0034,16'h0031,16'h002E,16'h002C,16'h0029,16'h0027,16'h0025,16'h0023,
    16'h0021,16'h001F,16'h001D,16'h001B,16'h001A,16'h0018,16'h0017,16'h0015,16'h0014,16'h0013,
    16'h0012,16'h0011,16'h0010,16'h000F,16'h000E,16'h000D,16'h000C,16'h000C,16'h000B,16'h000A,
    16'h000A,16'h0009,16'h0008,16'h0008,16'h0007,16'h0007,16'h0006,16'h0006,16'h0006,16'h0005,
    16'h0005,16'h0005,16'h0004,16'h0004,16'h0004,16'h0003,16'h0003,16'h0003,16'h0003,16'h0003,
    16'h0002,16'h0002,16'h0002,16'h0002,16'h0002,16'h0001,16'h0001,16'h0001,16'h0001,16'h0001,
    16'h0001,16'h0001,16'h0001,16'h0001,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000};
  localparam logic [15:0] DIV28 [129] = '{
    16'h110F,16'h101A,16'h0F33,16'h0E58,16'h0D8A,16'h0CC8,16'h0C10,16'h0B62,16'h0ABF,16'h0A24,
    16'h0993,16'h0909,16'h0887,16'h080D,16'h0799,16'h072C,16'h06C5,16'h0663,16'h0607,16'h05B1,
    16'h055F,16'h0512,16'h04C9,16'h0484,16'h0443,16'h0406,16'h03CC,16'h0395,16'h0362,16'h0331,
    16'h0303,16'h02D8,16'h02AF,16'h0288,16'h0264,16'h0242,16'h0221,16'h0202,16'h01E5,16'h01CA,
    16'h01B0,16'h0198,16'h0181,16'h016B,16'h0157,16'h0144,16'h0131,16'h0120,16'h0110,16'h0101,
    16'h00F2,16'h00E5,16'h00D8,16'h00CC,16'h00C0,16'h00B5,16'h00AB,16'h00A1,16'h0098,16'h0090,
    16'h0088,16'h0080,16'h0079,16'h0072,16'h006B,16'h0065,16'h0060,16'h005A,16'h0055,16'h0050,
    16'h004C,16'h0047,16'h0043,16'h003F,16'h003C,16'h0038,16'h0035,16'h0032,16'h002F,16'h002D,
    16'h002A,16'h0028,16'h0025,16'h0023,16'h0021,16'h001F,16'h001D,16'h001C,16'h001A,16'h0019,
    16'h0017,16'h0016,16'h0014,16'h0013,16'h0012,16'h0011,16'h0010,16'h000F,16'h000E,16'h000D,
    16'h000D,16'h000C,16'h000B,16'h000A,16'h000A,16'h0009,16'h0009,16'h0008,16'h0008,16'h0007,
    16'h0007,16'h0006,16'h0006,16'h0005,16'h0005,16'h0005,16'h0004,16'h0004,16'h0004,16'h0004,
    16'h0003,16'h0003,16'h0003,16'h0003,16'h0002,16'h0002,16'h0002,16'h0002,16'h0002};

  localparam logic [7:0] DIST_HI [9] = '{8'hA0, 8'h00, 8'h00, 8'h80, 8'h80, 8'h60, 8'h40,
                                         8'hC0, 8'hF0};
  localparam int JITTER_OFS [15] = '{2, 1, 0, -1, 1, 0, -1, -2, -3, 2, 1, 0, -1, 1, 0};
  // {pair 0/1, pair 2/3} table-select nibbles per oscillator mode
  localparam logic [15:0] PAIR_SEL [28] = '{
    16'h0000, 16'h1111, 16'h2F2F, 16'hF3F3, 16'hF4F4, 16'hF5F5,
    16'h00FF, 16'h0FFF, 16'h11FF, 16'h1FFF, 16'h2FFF, 16'h2FFF, 16'h2FFF,
    16'hF3FF, 16'hF4FF, 16'hF5FF, 16'hF5FF, 16'hF0FF, 16'hF0FF, 16'hF1FF, 16'hF1FF,
    16'hF3FF, 16'hF3FF, 16'hF4FF, 16'hF4FF, 16'hF5FF, 16'hF5FF, 16'hF5FF};
  // mix register masks per mode, channel 0 in the top byte
  localparam logic [31:0] MIX_CLR [28] = '{
    32'h55132D0B, 32'h54122C0A, 32'h14000C00, 32'h00470027, 32'h00460026, 32'h00060006,
    32'h79190000, 32'h59000000, 32'h78180000, 32'h58000000, 32'h39000000, 32'h38000000,
    32'h18000000, 32'h004D0000, 32'h004C0000, 32'h000D0000, 32'h000C0000, 32'h00750000,
    32'h00550000, 32'h00740000, 32'h00540000, 32'h00650000, 32'h00450000, 32'h00640000,
    32'h00440000, 32'h00250000, 32'h00240000, 32'h00040000};
  localparam logic [31:0] MIX_SET [28] = '{
    32'h00000000, 32'h01010101, 32'h40002000, 32'h00100008, 32'h00110009, 32'h00500028,
    32'h04020000, 32'h24000000, 32'h05030000, 32'h25000000, 32'h44000000, 32'h45000000,
    32'h64000000, 32'h00120000, 32'h00130000, 32'h00520000, 32'h00530000, 32'h000A0000,
    32'h002A0000, 32'h000B0000, 32'h002B0000, 32'h001A0000, 32'h003A0000, 32'h001B0000,
    32'h003B0000, 32'h005A0000, 32'h005B0000, 32'h007A0000};

  typedef struct {
    logic [1:0] chip;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  class reg_write_scoreboard;
    logic [7:0]   shadow [64];
    logic [4:0]   voice_osc [16];
    reg_write_t   pending_writes [$];
    int           n_errors;
    int           n_checked;
    int           n_jitter_notes;

    function new();
      for (int i = 0; i < 64; i++) shadow[i] = 8'h00;
      for (int c = 0; c < 4; c++) begin
        shadow[c*16+1] = 8'hA0;
        shadow[c*16+3] = 8'hA0;
        shadow[c*16+5] = 8'hA0;
        shadow[c*16+7] = 8'hA0;
        shadow[c*16+scvrw_pkg::SerialReg] = 8'h03;
      end
      for (int v = 0; v < 16; v++) voice_osc[v] = '0;
      n_errors = 0;
      n_checked = 0;
      n_jitter_notes = 0;
    endfunction

    function void put_write(logic [1:0] chip, logic [3:0] addr, int data);
      reg_write_t w;
      w.chip = chip;
      w.addr = addr;
      w.data = data[7:0];
      w.last = 1'b0;
      shadow[{chip, addr}] = data[7:0];
      pending_writes.push_back(w);
    endfunction

    function int divider(int sel, int idx);
      if (sel == 0 || sel == 3) return DIV28[idx];
      if (sel == 1 || sel == 4) return DIV114[idx];
      return BASE_DIV[idx];
    endfunction

    function void predict_note(logic [1:0] chip, logic [1:0] ch, logic [4:0] m,
                               logic signed [15:0] p);
      int note, sel, idx, rem, val, nxt;
      logic [15:0] cfg;
      logic [3:0] addr;
      note = p;
      if (note < 0) note = 0;
      if (note > scvrw_pkg::NoteMax) note = scvrw_pkg::NoteMax;
      cfg = PAIR_SEL[m];
      sel = ch[1] ? (ch[0] ? cfg[3:0] : cfg[7:4]) : (ch[0] ? cfg[11:8] : cfg[15:12]);
      if (sel > 5) return;
      addr = {1'b0, ch, 1'b0};
      idx = note >> 7;
      rem = note & 'h7F;
      val = divider(sel, idx);
      if (rem != 0 && idx < 128) begin
        nxt = divider(sel, idx + 1);
        if (val >= nxt) val = val - (((val - nxt) * rem) >> 7);
      end
      if (sel < 3) begin
        put_write(chip, addr, (val > 255) ? 255 : val);
      end else if (addr >= 2) begin
        if (shadow[{chip, addr + 4'd1}][7:4] == 4'hC) begin
          val = val + JITTER_OFS[val % 15];
          if (val < 0) val = 0;
          if (val > 65535) val = 65535;
          put_write(chip, addr, val >> 8);
          put_write(chip, addr - 4'd2, val & 'hFF);
          put_write(chip, scvrw_pkg::TimerReg, 0);
          n_jitter_notes++;
        end else begin
          put_write(chip, addr, val >> 8);
          put_write(chip, addr - 4'd2, val & 'hFF);
        end
      end
    endfunction

    // Accepted command: work out the writes it causes and queue them.
    function void note_input(logic [2:0] c, logic [3:0] v, logic signed [15:0] p,
                             logic [15:0] op);
      logic [1:0] chip, ch;
      logic [3:0] ctl;
      logic [4:0] m;
      logic [7:0] mix;
      int before_n;
      chip = v[3:2];
      ch = v[1:0];
      ctl = {1'b0, ch, 1'b1};
      m = voice_osc[v];
      before_n = pending_writes.size();
      case (c)
        scvrw_pkg::CMD_NOTE: predict_note(chip, ch, m, p);
        scvrw_pkg::CMD_VOL:
          put_write(chip, ctl, ((op > 127) ? 127 : op) / 8 | (shadow[{chip, ctl}] & 8'hF0));
        scvrw_pkg::CMD_MODE:
          if (op < 28) begin
            voice_osc[v] = op[4:0];
            mix = shadow[{chip, scvrw_pkg::MixReg}];
            mix = mix & ~MIX_CLR[op][8*(3-ch) +: 8];
            mix = mix | MIX_SET[op][8*(3-ch) +: 8];
            put_write(chip, scvrw_pkg::MixReg, mix);
          end
        scvrw_pkg::CMD_DIST:
          if (op < 9) begin
            put_write(chip, ctl, (shadow[{chip, ctl}] & 8'h0F) | DIST_HI[op]);
            mix = shadow[{chip, scvrw_pkg::MixReg}];
            if (op == 2 || op == 4) mix = mix | 8'h80;
            else mix = mix & 8'h7F;
            put_write(chip, scvrw_pkg::MixReg, mix);
          end
        scvrw_pkg::CMD_FILT:
          if (ch == 0) begin
            if (m >= 6 && m < 13) put_write(chip, scvrw_pkg::LowFiltReg, op >> 8);
          end else if (ch == 1) begin
            if (m == 6 || m == 8 || (m >= 13 && m < 28)) begin
              put_write(chip, scvrw_pkg::HighFiltReg, op >> 8);
              if (m >= 17) put_write(chip, scvrw_pkg::LowFiltReg, op & 'hFF);
            end
          end
        default: ;
      endcase
      if (pending_writes.size() > before_n)
        pending_writes[pending_writes.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] chip, logic [3:0] addr, logic [7:0] data,
                               logic last);
      reg_write_t w;
      n_checked++;
      if (pending_writes.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected write chip=%0d addr=%0d data=%h last=%b",
                   chip, addr, data, last);
        return;
      end
      w = pending_writes.pop_front();
      if (w.chip !== chip || w.addr !== addr || w.data !== data || w.last !== last) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: write mismatch exp chip=%0d addr=%0d data=%h last=%b,",
                   w.chip, w.addr, w.data, w.last,
                   " got chip=%0d addr=%0d data=%h last=%b",
                   chip, addr, data, last);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [2:0]         cmd;
  logic [3:0]         voice;
  logic signed [15:0] pitch;
  logic [15:0]        operand;
  logic               empty;
  logic               pop;
  logic [1:0]         chip_sel;
  logic [3:0]         reg_addr;
  logic [7:0]         reg_data;
  logic               last;

  reg_write_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int n_sent;
  int cycle_count;

  sound_chip_voice_register_writer DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .voice(voice),
    .pitch(pitch), .operand(operand), .empty(empty), .pop(pop), .chip_sel(chip_sel),
    .reg_addr(reg_addr), .reg_data(reg_data), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random pop, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else if (rx_hold > 0) begin
      rx_hold--;
      pop = 1'b0;
    end else pop = ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(chip_sel, reg_addr, reg_data, last);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(scvrw_pkg::cmd_t c, logic [3:0] v, logic [15:0] p,
                          logic [15:0] op);
    if ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    cmd = c;
    voice = v;
    pitch = p;
    operand = op;
    push = 1'b1;
    do @(posedge clk); while (full);
    sb.note_input(cmd, voice, pitch, operand);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random();
    int k;
    scvrw_pkg::cmd_t c;
    logic [15:0] p, op;
    k = $urandom_range(99);
    p = $urandom;
    op = $urandom;
    if (k < 35) begin
      c = scvrw_pkg::CMD_NOTE;
      if ($urandom_range(3) != 0) p = $urandom_range(scvrw_pkg::NoteMax);
    end else if (k < 50) begin
      c = scvrw_pkg::CMD_VOL;
      if ($urandom_range(3) != 0) op = $urandom_range(160);
    end else if (k < 68) begin
      c = scvrw_pkg::CMD_MODE;
      if ($urandom_range(7) != 0) op = $urandom_range(27);
    end else if (k < 83) begin
      c = scvrw_pkg::CMD_DIST;
      // lean on the jitter nibble so 16-bit notes pick up the third write
      if ($urandom_range(7) != 0) op = ($urandom_range(2) == 0) ? 7 : $urandom_range(8);
    end else if (k < 96) begin
      c = scvrw_pkg::CMD_FILT;
    end else begin
      c = scvrw_pkg::cmd_t'($urandom_range(7, 5));
    end
    send_cmd(c, $urandom_range(15), p, op);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cmd = scvrw_pkg::CMD_NOTE;
    voice = '0;
    pitch = '0;
    operand = '0;
    tx_idle_pct = 22;
    rx_idle_pct = 79;
    rx_hold = 0;
    n_sent = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd0, 16'h8000, 16'h0000);   // most negative pitch
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd15, 16'h7FFF, 16'hFFFF);  // clamps to top note
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd2, 16'd16256, 16'h0000);
    send_cmd(scvrw_pkg::CMD_VOL, 4'd3, 16'h0000, 16'd0);
    send_cmd(scvrw_pkg::CMD_VOL, 4'd3, 16'h0000, 16'd127);
    send_cmd(scvrw_pkg::CMD_VOL, 4'd7, 16'h0000, 16'hFFFF);
    send_cmd(scvrw_pkg::CMD_MODE, 4'd1, 16'h0000, 16'd28);     // ignored
    send_cmd(scvrw_pkg::CMD_MODE, 4'd1, 16'h0000, 16'd3);      // 16-bit on channel 1
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd0, 16'd1000, 16'h0000);   // voice 0 still in mode 0: one 8-bit write
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd1, 16'd1000, 16'h0000);
    send_cmd(scvrw_pkg::CMD_DIST, 4'd1, 16'h0000, 16'd9);      // ignored
    send_cmd(scvrw_pkg::CMD_DIST, 4'd1, 16'h0000, 16'd7);      // arms jitter
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd1, 16'd5000, 16'h0000);
    send_cmd(scvrw_pkg::CMD_NOTE, 4'd1, 16'd0, 16'h0000);
    send_cmd(scvrw_pkg::CMD_DIST, 4'd5, 16'h0000, 16'd2);
    send_cmd(scvrw_pkg::CMD_DIST, 4'd5, 16'h0000, 16'd8);
    send_cmd(scvrw_pkg::CMD_MODE, 4'd0, 16'h0000, 16'd6);
    send_cmd(scvrw_pkg::CMD_FILT, 4'd0, 16'h0000, 16'hFFFF);
    send_cmd(scvrw_pkg::CMD_MODE, 4'd1, 16'h0000, 16'd27);
    send_cmd(scvrw_pkg::CMD_FILT, 4'd1, 16'h0000, 16'hA55A);
    send_cmd(scvrw_pkg::CMD_FILT, 4'd2, 16'h0000, 16'h1234);   // channel 2 never filters
    send_cmd(scvrw_pkg::cmd_t'(3'd5), 4'd4, 16'h0000, 16'h0000);
    send_cmd(scvrw_pkg::cmd_t'(3'd7), 4'd8, 16'hFFFF, 16'hFFFF);

    repeat (65) send_random();
    tx_idle_pct = 79;
    rx_idle_pct = 22;
    repeat (60) send_random();

    // hold-off: receiver stalls while the sender keeps pushing
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 400;
    repeat (30) send_random();
    wait_drained();
    repeat (40) send_random();
    wait_drained();

    $display("Sent %0d commands, checked %0d register writes (%0d jittered notes).",
             n_sent, sb.n_checked, sb.n_jitter_notes);
    $display("Mismatches: %0d", sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
